// ----- rtl/bla_pkg.sv -----
// Shared types, constants and tables for the ballistic launch angle core.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package bla_pkg;

    localparam int GRAV_W       = 12;
    localparam int SPEED_W      = 14;
    localparam int V2_W         = 2 * SPEED_W;
    localparam int V4_W         = 2 * V2_W;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int ANG_W        = 32;
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_IN_W  = 54;
    localparam int SQRT_W       = 64;
    localparam int SQRT_STEPS   = 32;

    localparam logic [GRAV_W-1:0]  GRAVITY_RESET = 12'd980;
    localparam logic [SPEED_W-1:0] SPEED_RESET   = 14'd1500;

    localparam logic [ANG_W-1:0] ANG_HALF        = 32'h8000_0000;
    localparam logic [ANG_W-1:0] ANG_QUARTER     = 32'h4000_0000;
    localparam logic [ANG_W-1:0] ANG_NEG_QUARTER = 32'hC000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAVITY      = 8'd0,
        REG_LAUNCH_SPEED = 8'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [SQRT_W-1:0] n;
        logic [SQRT_W-1:0] r;
    } sq_pair_t;

    // atan(2^-i) in 2^32 units per turn
    function automatic logic [ANG_W-1:0] atan_step(input int i);
        logic [ANG_W-1:0] a;
        case (i)
            0:  a = 32'd536870912;
            1:  a = 32'd316933406;
            2:  a = 32'd167458907;
            3:  a = 32'd85004756;
            4:  a = 32'd42667331;
            5:  a = 32'd21354465;
            6:  a = 32'd10679838;
            7:  a = 32'd5340245;
            8:  a = 32'd2670163;
            9:  a = 32'd1335087;
            10: a = 32'd667544;
            11: a = 32'd333772;
            12: a = 32'd166886;
            13: a = 32'd83443;
            14: a = 32'd41722;
            15: a = 32'd20861;
            16: a = 32'd10430;
            17: a = 32'd5215;
            18: a = 32'd2608;
            19: a = 32'd1304;
            20: a = 32'd652;
            21: a = 32'd326;
            22: a = 32'd163;
            23: a = 32'd81;
            24: a = 32'd41;
            25: a = 32'd20;
            26: a = 32'd10;
            27: a = 32'd5;
            default: a = '0;
        endcase
        return a;
    endfunction

    // one digit of a restoring square root, k counts from the top digit
    function automatic sq_pair_t sqrt_step(input sq_pair_t p, input int k);
        logic [SQRT_W-1:0] b;
        logic [SQRT_W-1:0] trial;
        sq_pair_t q;
        b = SQRT_W'(1) << (62 - 2 * k);
        trial = p.r + b;
        if (p.n >= trial) begin
            q.n = p.n - trial;
            q.r = (p.r >> 1) + b;
        end else begin
            q.n = p.n;
            q.r = p.r >> 1;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bla_cordic.sv -----
// Pipelined CORDIC vectoring unit: atan2(y, x) in 2^32 units per turn.
// One prerotation stage and one stage per step; depends on bla_pkg.
`default_nettype none

module bla_cordic (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [bla_pkg::CORDIC_IN_W-1:0] x_in,
    input  logic signed [bla_pkg::CORDIC_IN_W-1:0] y_in,
    output logic        [bla_pkg::ANG_W-1:0]       ang_out
);
    import bla_pkg::*;

    localparam int W = CORDIC_IN_W + 2;

    logic signed [W-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [W-1:0] y_reg [0:CORDIC_STEPS];
    logic [ANG_W-1:0]    a_reg [0:CORDIC_STEPS];

    logic signed [W-1:0] x_ext;
    logic signed [W-1:0] y_ext;

    assign x_ext = W'(x_in);
    assign y_ext = W'(y_in);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (x_in < 0) begin
                x_reg[0] <= -x_ext;
                y_reg[0] <= -y_ext;
                a_reg[0] <= ANG_HALF;
            end else begin
                x_reg[0] <= x_ext;
                y_reg[0] <= y_ext;
                a_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [W-1:0] xs;
        logic signed [W-1:0] ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    a_reg[i+1] <= a_reg[i] + atan_step(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    a_reg[i+1] <= a_reg[i] - atan_step(i);
                end
            end
        end
    end

    assign ang_out = a_reg[CORDIC_STEPS];

endmodule

`default_nettype wire

// ----- rtl/ballistic_launch_angle_core.sv -----
// Low-arc launch pitch and heading from start and end points, fully pipelined.
// Depends on bla_pkg and bla_cordic.
//
//   channel  | direction | handshake              | payload
//   s_       | in        | s_valid / s_ready      | start_x/y/z, end_x/y/z
//   m_       | out       | m_valid / m_ready      | reachable, pitch_angle, yaw_angle
//   cfg_     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle while not stalled. Stages: 9 arithmetic, 32 square root digit,
// one scaling, 29 CORDIC and the output register.
// Reset clears the valid bits and sets gravity 980, launch speed 1500.
// The whole pipeline advances while the output register is empty or being taken;
// a stall freezes every stage in place.
`default_nettype none

module ballistic_launch_angle_core #(
    parameter int COORD_BITS = 24,
    parameter int ANGLE_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_BITS-1:0]         s_start_x,
    input  logic signed [COORD_BITS-1:0]         s_start_y,
    input  logic signed [COORD_BITS-1:0]         s_start_z,
    input  logic signed [COORD_BITS-1:0]         s_end_x,
    input  logic signed [COORD_BITS-1:0]         s_end_y,
    input  logic signed [COORD_BITS-1:0]         s_end_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_reachable,
    output logic signed [ANGLE_BITS-1:0]         m_pitch_angle,
    output logic signed [ANGLE_BITS-1:0]         m_yaw_angle,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [bla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [bla_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bla_pkg::*;

    localparam int DW  = COORD_BITS + 1;
    localparam int DVW = DW + V2_W + 1;

    typedef struct packed {
        logic                 vld;
        logic                 ok;
        logic                 xzero;
        logic                 dz_pos;
        logic                 dz_neg;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
    } side_t;

    function automatic logic [ANGLE_BITS-1:0] to_angle(input logic [ANG_W-1:0] a);
        logic [ANG_W-1:0] s;
        s = a + (ANG_W'(1) << (31 - ANGLE_BITS));
        return s[ANG_W-1 -: ANGLE_BITS];
    endfunction

    logic              en;
    logic [GRAV_W-1:0]  gravity_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [GRAV_W-1:0]  g_reg;
    logic [V2_W-1:0]    v2_reg;
    logic [V4_W-1:0]    v4_reg;

    logic                  m_valid_reg;
    logic                  m_reach_reg;
    logic [ANGLE_BITS-1:0] m_pitch_reg;
    logic [ANGLE_BITS-1:0] m_yaw_reg;

    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg <= GRAVITY_RESET;
            speed_reg   <= SPEED_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_GRAVITY:      gravity_reg <= cfg_data[GRAV_W-1:0];
                REG_LAUNCH_SPEED: speed_reg   <= cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        g_reg  <= (gravity_reg == '0) ? GRAV_W'(1) : gravity_reg;
        v2_reg <= V2_W'(speed_reg) * V2_W'(speed_reg);
        v4_reg <= V4_W'(v2_reg) * V4_W'(v2_reg);
    end

    // stage 1: differences
    side_t                side1_next, side1_reg;
    logic signed [DW-1:0] dz1_next, dz1_reg;

    always_comb begin
        side1_next.vld    = s_valid;
        side1_next.ok     = 1'b1;
        side1_next.dx     = DW'(s_end_x) - DW'(s_start_x);
        side1_next.dy     = DW'(s_end_y) - DW'(s_start_y);
        side1_next.xzero  = (s_end_x == s_start_x) && (s_end_y == s_start_y);
        side1_next.dz_pos = s_end_z > s_start_z;
        side1_next.dz_neg = s_end_z < s_start_z;
        dz1_next          = DW'(s_end_z) - DW'(s_start_z);
    end

    // stage 2: magnitudes
    side_t                side2_reg;
    logic [DW-1:0]        ax2_reg, ay2_reg;
    logic signed [DW-1:0] dz2_reg;

    // stage 3: range check, squares
    side_t                side3_next, side3_reg;
    logic [63:0]          ax64, ay64;
    logic [61:0]          sqx3_reg, sqy3_reg;
    logic signed [DW-1:0] dz3_reg;

    assign ax64 = 64'(ax2_reg);
    assign ay64 = 64'(ay2_reg);

    always_comb begin
        side3_next    = side2_reg;
        side3_next.ok = side2_reg.ok && (ax64 < 64'h8000_0000) && (ay64 < 64'h8000_0000);
    end

    // stage 4: squared horizontal distance
    side_t                side4_reg;
    logic [62:0]          x2_4_reg;
    logic signed [DW-1:0] dz4_reg;

    // stage 5: g*x^2 and dz*v^2
    side_t                 side5_reg;
    logic [74:0]           gx2_5_reg;
    logic signed [DVW-1:0] dzv5_next, dzv5_reg;
    logic [62:0]           x2_5_reg;

    assign dzv5_next = DVW'(dz4_reg) * $signed(DVW'(v2_reg));

    // stage 6: t = g*x^2 + 2*dz*v^2
    side_t              side6_next, side6_reg;
    logic signed [65:0] t6_next, t6_reg;
    logic [62:0]        x2_6_reg;

    always_comb begin
        side6_next    = side5_reg;
        side6_next.ok = side5_reg.ok && (gx2_5_reg <= (75'(1) << 62));
        t6_next       = $signed({3'b000, gx2_5_reg[62:0]}) + (66'(dzv5_reg) <<< 1);
    end

    // stage 7: g*t
    side_t              side7_reg;
    logic signed [78:0] gt7_reg;
    logic [62:0]        x2_7_reg;

    // stage 8: discriminant
    side_t              side8_next, side8_reg;
    logic signed [79:0] d_full;
    logic [62:0]        d8_reg;
    logic [62:0]        x2_8_reg;

    always_comb begin
        d_full        = $signed(80'(v4_reg)) - 80'(gt7_reg);
        side8_next    = side7_reg;
        side8_next.ok = side7_reg.ok && !d_full[79] && (d_full[78:63] == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side1_reg <= '0;
            side2_reg <= '0;
            side3_reg <= '0;
            side4_reg <= '0;
            side5_reg <= '0;
            side6_reg <= '0;
            side7_reg <= '0;
            side8_reg <= '0;
        end else if (en) begin
            side1_reg <= side1_next;
            side2_reg <= side1_reg;
            side3_reg <= side3_next;
            side4_reg <= side3_reg;
            side5_reg <= side4_reg;
            side6_reg <= side6_next;
            side7_reg <= side6_reg;
            side8_reg <= side8_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dz1_reg   <= dz1_next;
            ax2_reg   <= side1_reg.dx[DW-1] ? DW'(-side1_reg.dx) : DW'(side1_reg.dx);
            ay2_reg   <= side1_reg.dy[DW-1] ? DW'(-side1_reg.dy) : DW'(side1_reg.dy);
            dz2_reg   <= dz1_reg;
            sqx3_reg  <= {31'd0, ax64[30:0]} * {31'd0, ax64[30:0]};
            sqy3_reg  <= {31'd0, ay64[30:0]} * {31'd0, ay64[30:0]};
            dz3_reg   <= dz2_reg;
            x2_4_reg  <= 63'(sqx3_reg) + 63'(sqy3_reg);
            dz4_reg   <= dz3_reg;
            gx2_5_reg <= 75'(g_reg) * 75'(x2_4_reg);
            dzv5_reg  <= dzv5_next;
            x2_5_reg  <= x2_4_reg;
            t6_reg    <= t6_next;
            x2_6_reg  <= x2_5_reg;
            gt7_reg   <= $signed(79'(g_reg)) * 79'(t6_reg);
            x2_7_reg  <= x2_6_reg;
            d8_reg    <= d_full[62:0];
            x2_8_reg  <= x2_7_reg;
        end
    end

    // stage 9 and square root digit stages
    side_t    sq_side_reg [0:SQRT_STEPS];
    sq_pair_t sqx_reg     [0:SQRT_STEPS];
    sq_pair_t sqd_reg     [0:SQRT_STEPS];
    logic     sqx_big_reg [0:SQRT_STEPS];
    logic     sqd_big_reg [0:SQRT_STEPS];
    logic     x_big, d_big;

    assign x_big = x2_8_reg >= (63'(1) << 48);
    assign d_big = d8_reg >= (63'(1) << 48);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_side_reg[0] <= '0;
        end else if (en) begin
            sq_side_reg[0] <= side8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg[0].n   <= x_big ? SQRT_W'(x2_8_reg) : (SQRT_W'(x2_8_reg) << 14);
            sqx_reg[0].r   <= '0;
            sqd_reg[0].n   <= d_big ? SQRT_W'(d8_reg) : (SQRT_W'(d8_reg) << 14);
            sqd_reg[0].r   <= '0;
            sqx_big_reg[0] <= x_big;
            sqd_big_reg[0] <= d_big;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_side_reg[k+1] <= '0;
            end else if (en) begin
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sqx_reg[k+1]     <= sqrt_step(sqx_reg[k], k);
                sqd_reg[k+1]     <= sqrt_step(sqd_reg[k], k);
                sqx_big_reg[k+1] <= sqx_big_reg[k];
                sqd_big_reg[k+1] <= sqd_big_reg[k];
            end
        end
    end

    // scaling stage: atan2 operands
    logic [38:0]        sx, sd;
    side_t              side_den_reg;
    logic [50:0]        den_reg;
    logic signed [40:0] num_reg;

    assign sx = sqx_big_reg[SQRT_STEPS] ? {sqx_reg[SQRT_STEPS].r[31:0], 7'd0}
                                        : 39'(sqx_reg[SQRT_STEPS].r[31:0]);
    assign sd = sqd_big_reg[SQRT_STEPS] ? {sqd_reg[SQRT_STEPS].r[31:0], 7'd0}
                                        : 39'(sqd_reg[SQRT_STEPS].r[31:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_den_reg <= '0;
        end else if (en) begin
            side_den_reg <= sq_side_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= 51'(g_reg) * 51'(sx);
            num_reg <= $signed(41'({v2_reg, 7'd0})) - $signed(41'(sd));
        end
    end

    // CORDIC stages
    logic [ANG_W-1:0] pitch_ang, yaw_ang;
    side_t            cs_reg [0:CORDIC_STEPS];

    bla_cordic u_pitch (
        .aclk    (aclk),
        .en      (en),
        .x_in    ($signed(CORDIC_IN_W'(den_reg))),
        .y_in    (CORDIC_IN_W'(num_reg)),
        .ang_out (pitch_ang)
    );

    bla_cordic u_yaw (
        .aclk    (aclk),
        .en      (en),
        .x_in    (CORDIC_IN_W'(side_den_reg.dx)),
        .y_in    (CORDIC_IN_W'(side_den_reg.dy)),
        .ang_out (yaw_ang)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cs_reg[0] <= '0;
        end else if (en) begin
            cs_reg[0] <= side_den_reg;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cside
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cs_reg[i+1] <= '0;
            end else if (en) begin
                cs_reg[i+1] <= cs_reg[i];
            end
        end
    end

    // output register
    side_t                 last;
    logic [ANGLE_BITS-1:0] pitch_next, yaw_next;

    assign last = cs_reg[CORDIC_STEPS];

    always_comb begin
        if (!last.ok) begin
            pitch_next = '0;
            yaw_next   = '0;
        end else if (last.xzero) begin
            yaw_next = '0;
            if (last.dz_pos) begin
                pitch_next = to_angle(ANG_QUARTER);
            end else if (last.dz_neg) begin
                pitch_next = to_angle(ANG_NEG_QUARTER);
            end else begin
                pitch_next = '0;
            end
        end else begin
            pitch_next = to_angle(pitch_ang);
            yaw_next   = to_angle(yaw_ang);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= last.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reach_reg <= last.ok;
            m_pitch_reg <= pitch_next;
            m_yaw_reg   <= yaw_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_reachable   = m_reach_reg;
    assign m_pitch_angle = m_pitch_reg;
    assign m_yaw_angle   = m_yaw_reg;

endmodule

`default_nettype wire

// ----- rtl/bla_checker.sv -----
// Port-level checks for ballistic_launch_angle_core, attached by bind.
// Depends only on the port and parameter names of the core.
`default_nettype none

module bla_checker #(
    parameter int COORD_BITS = 24,
    parameter int ANGLE_BITS = 16
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic signed [COORD_BITS-1:0]         s_start_x,
    input logic signed [COORD_BITS-1:0]         s_start_y,
    input logic signed [COORD_BITS-1:0]         s_start_z,
    input logic signed [COORD_BITS-1:0]         s_end_x,
    input logic signed [COORD_BITS-1:0]         s_end_y,
    input logic signed [COORD_BITS-1:0]         s_end_z,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic                                 m_reachable,
    input logic signed [ANGLE_BITS-1:0]         m_pitch_angle,
    input logic signed [ANGLE_BITS-1:0]         m_yaw_angle
);

    localparam int QTR = 1 << (ANGLE_BITS - 2);

    a_request_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_start_x) && $stable(s_start_y)
            && $stable(s_start_z) && $stable(s_end_x) && $stable(s_end_y)
            && $stable(s_end_z))
        else $error("request changed while waiting");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_reachable)
            && $stable(m_pitch_angle) && $stable(m_yaw_angle))
        else $error("result changed while stalled");

    a_unreachable_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reachable |-> m_pitch_angle == '0 && m_yaw_angle == '0)
        else $error("unreachable result carries nonzero angles");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reachable |-> int'(m_pitch_angle) <= QTR && int'(m_pitch_angle) >= -QTR)
        else $error("pitch beyond a quarter turn");

    a_ready_coupling: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

endmodule

bind ballistic_launch_angle_core bla_checker #(
    .COORD_BITS(COORD_BITS),
    .ANGLE_BITS(ANGLE_BITS)
) u_bla_checker (.*);

`default_nettype wire
